### rtl/core/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and constants of the page framebuffer blit core
// Command and register codes, default screen size, and the operation word
// that travels from the front end to the memory back end.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int DEF_SCREEN_COLUMNS = 128;
  localparam int DEF_SCREEN_PAGES   = 8;
  localparam int QUEUE_DEPTH        = 4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DEST_COLUMN  = 2'd0,
    REG_DEST_ROW     = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_ZERO  = 2'd3
  } op_kind_t;

  // Field widths cover the largest screen (256 columns, 16 pages).
  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  col_lo;   // clear: first column; draw/read: the column
    logic [8:0]  col_hi;   // clear: end column, exclusive
    logic [3:0]  pg_lo;    // clear: first page; draw: upper page; read: page
    logic [3:0]  pg_hi;    // clear: last page
    logic [2:0]  row_lo;   // clear: first row inside first page
    logic [2:0]  row_hi;   // clear: last row inside last page
    logic        en0;      // draw: OR data0 into upper page
    logic        en1;      // draw: OR data1 into the page below
    logic [7:0]  data0;
    logic [7:0]  data1;
  } op_t;

endpackage

### rtl/core/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata <= mem_r[addr];
      end
    end
  end

endmodule

### rtl/core/pfb_queue.sv
// ----------------------------------------------------------------------------
// pfb_queue: short operation queue between front end and back end
// Register FIFO of operation words; the head is shown while not empty.
// ----------------------------------------------------------------------------
module pfb_queue import pfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  head,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### rtl/core/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front: command front end
// Holds the configuration registers and the image stream counters, clips
// each command against the screen and queues the memory work it needs.
// ----------------------------------------------------------------------------
module pfb_front import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = DEF_SCREEN_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_pixel_byte,
  input  logic [2:0] in_read_page,
  input  logic [6:0] in_read_column,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       init_done,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  localparam logic [8:0]        COLS9    = 9'(SCREEN_COLUMNS);
  localparam logic [4:0]        PAGES5   = 5'(SCREEN_PAGES);
  localparam logic signed [9:0] PAGES10  = 10'(SCREEN_PAGES);
  localparam logic signed [9:0] ROWS10   = 10'(8 * SCREEN_PAGES);

  logic              [7:0] dest_column_r;
  logic              [7:0] dest_row_r;
  logic              [7:0] image_width_r;
  logic              [6:0] image_height_r;
  logic              [3:0] row_cnt_r, row_cnt_nxt;
  logic              [7:0] col_cnt_r, col_cnt_nxt;
  logic                    active_r, active_nxt;

  logic                    accept;
  logic signed [9:0]       y10, ht10, vis10, top10, h10, end10, end_clip10, last10;
  logic                    y_neg, drawable;
  logic        [7:0]       pc_sum;
  logic        [4:0]       pc5;
  logic        [8:0]       col_end9, col_end_clip9;
  logic signed [9:0]       base10, pg10, pg1_10, vis_pg10, limpg10;
  logic        [15:0]      wide;
  logic        [8:0]       col9;
  logic                    col_ok, in_range, en0, en1;

  assign cfg_ready = 1'b1;
  assign in_stall  = !init_done || q_full;
  assign accept    = in_valid && !in_stall;

  // Geometry shared by start and image byte commands.
  always_comb begin
    y10      = {{2{dest_row_r[7]}}, dest_row_r};
    y_neg    = dest_row_r[7];
    ht10     = {3'b000, image_height_r};
    vis10    = ht10 + y10;
    pc_sum   = {1'b0, image_height_r} + 8'd7;
    pc5      = pc_sum[7:3];

    drawable = ({1'b0, dest_column_r} < COLS9) && (y10 < ROWS10)
               && (!y_neg || (!vis10[9] && vis10 != '0));
    top10      = y_neg ? '0 : y10;
    h10        = y_neg ? vis10 : ht10;
    end10      = top10 + h10;
    end_clip10 = (end10 > ROWS10) ? ROWS10 : end10;
    last10     = end_clip10 - 10'sd1;
    col_end9      = {1'b0, dest_column_r} + {1'b0, image_width_r};
    col_end_clip9 = (col_end9 > COLS9) ? COLS9 : col_end9;

    // Rows below the last visible image page are dropped for a clipped top.
    vis_pg10 = (vis10 + 10'sd7) >>> 3;
    if (!y_neg) begin
      limpg10 = PAGES10;
    end else if (vis10[9] || vis10 == '0) begin
      limpg10 = '0;
    end else if (vis_pg10 > PAGES10) begin
      limpg10 = PAGES10;
    end else begin
      limpg10 = vis_pg10;
    end

    base10   = y10 + {3'b000, row_cnt_r, 3'b000};
    pg10     = base10 >>> 3;
    pg1_10   = pg10 + 10'sd1;
    wide     = {8'h00, in_pixel_byte} << base10[2:0];
    col9     = {1'b0, dest_column_r} + {1'b0, col_cnt_r};
    col_ok   = col9 < COLS9;
    in_range = (col_cnt_r < image_width_r) && ({1'b0, row_cnt_r} < pc5);
    en0      = !pg10[9] && (pg10 < limpg10) && col_ok && (wide[7:0] != '0);
    en1      = !pg1_10[9] && (pg1_10 < limpg10) && col_ok && (wide[15:8] != '0);
  end

  always_comb begin
    q_push      = 1'b0;
    q_op        = '0;
    q_op.kind   = OP_ZERO;
    active_nxt  = active_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    unique case (cmd_t'(in_command))
      CMD_START: begin
        row_cnt_nxt  = '0;
        col_cnt_nxt  = '0;
        active_nxt   = drawable && image_width_r != '0 && image_height_r != '0;
        q_push       = drawable && image_width_r != '0;
        q_op.kind    = OP_CLEAR;
        q_op.col_lo  = dest_column_r;
        q_op.col_hi  = col_end_clip9;
        q_op.pg_lo   = top10[6:3];
        q_op.row_lo  = top10[2:0];
        q_op.pg_hi   = last10[6:3];
        q_op.row_hi  = last10[2:0];
      end
      CMD_PIXEL: begin
        q_op.kind   = OP_DRAW;
        q_op.col_lo = col9[7:0];
        q_op.pg_lo  = pg10[3:0];
        q_op.en0    = en0;
        q_op.en1    = en1;
        q_op.data0  = wide[7:0];
        q_op.data1  = wide[15:8];
        if (active_r) begin
          if (!in_range) begin
            active_nxt  = 1'b0;
            row_cnt_nxt = '0;
            col_cnt_nxt = '0;
          end else begin
            q_push = en0 || en1;
            if ({1'b0, col_cnt_r} + 9'd1 >= {1'b0, image_width_r}) begin
              if ({1'b0, row_cnt_r} + 5'd1 >= pc5) begin
                active_nxt  = 1'b0;
                row_cnt_nxt = '0;
                col_cnt_nxt = '0;
              end else begin
                col_cnt_nxt = '0;
                row_cnt_nxt = row_cnt_r + 4'd1;
              end
            end else begin
              col_cnt_nxt = col_cnt_r + 8'd1;
            end
          end
        end
      end
      CMD_READ: begin
        q_push      = 1'b1;
        q_op.col_lo = {1'b0, in_read_column};
        q_op.pg_lo  = {1'b0, in_read_page};
        if ({2'b00, in_read_page} < PAGES5 && {2'b00, in_read_column} < COLS9) begin
          q_op.kind = OP_READ;
        end else begin
          q_op.kind = OP_ZERO;
        end
      end
      CMD_NONE: begin
        q_push = 1'b0;
      end
    endcase
    q_push = q_push && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (accept) begin
      active_r  <= active_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_column_r  <= 8'd0;
      dest_row_r     <= 8'd0;
      image_width_r  <= 8'd0;
      image_height_r <= 7'd8;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEST_COLUMN:  dest_column_r  <= cfg_data;
        REG_DEST_ROW:     dest_row_r     <= cfg_data;
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[6:0];
      endcase
    end
  end

endmodule

### rtl/core/pfb_back.sv
// ----------------------------------------------------------------------------
// pfb_back: frame memory back end
// Clears the frame memory after reset, then runs queued operations as
// read-modify-write sequences on the single-port frame memory and returns
// read results through an output register.
// ----------------------------------------------------------------------------
module pfb_back import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = DEF_SCREEN_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  op_t        q_head,
  output logic       q_pop,
  output logic       init_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);

  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int PG_W   = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int ADDR_W = PG_W + COL_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CLR_RD, ST_CLR_WR, ST_DRW_RD, ST_DRW_WR, ST_RD_WAIT
  } state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  init_addr_r;
  op_t                op_r;
  logic [3:0]         cur_pg_r;
  logic [8:0]         cur_col_r;
  logic               second_r;
  logic               out_valid_r;
  logic [7:0]         out_data_r;

  logic               ram_en, ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               out_free, head_is_rd, out_load;
  logic [3:0]         head_pg;
  logic [2:0]         mask_lo, mask_hi;
  logic [7:0]         clr_mask;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] pg, input logic [8:0] col);
    addr_of = {pg[PG_W-1:0], col[COL_W-1:0]};
  endfunction

  assign init_done     = (state_r != ST_INIT);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_free      = !out_valid_r || !out_stall;
  assign head_is_rd    = (q_head.kind == OP_READ) || (q_head.kind == OP_ZERO);
  assign q_pop         = (state_r == ST_IDLE) && !q_empty && (!head_is_rd || out_free);
  assign head_pg       = (q_head.kind == OP_DRAW && !q_head.en0) ? q_head.pg_lo + 4'd1
                                                               : q_head.pg_lo;
  // A new result word loads the output register this cycle.
  assign out_load      = (state_r == ST_RD_WAIT)
                         || ((state_r == ST_IDLE) && q_pop && (q_head.kind == OP_ZERO));

  // Row mask of the clear rectangle within the current page.
  always_comb begin
    mask_lo = (cur_pg_r == op_r.pg_lo) ? op_r.row_lo : 3'd0;
    mask_hi = (cur_pg_r == op_r.pg_hi) ? op_r.row_hi : 3'd7;
    for (int k = 0; k < 8; k++) begin
      clr_mask[k] = (3'(k) >= mask_lo) && (3'(k) <= mask_hi);
    end
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_of(cur_pg_r, cur_col_r);
    ram_wdata = ram_rdata;
    unique case (state_r)
      ST_INIT: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = init_addr_r;
        ram_wdata = 8'h00;
      end
      ST_IDLE: begin
        ram_en   = q_pop && (q_head.kind != OP_ZERO);
        ram_addr = addr_of(head_pg, {1'b0, q_head.col_lo});
      end
      ST_CLR_RD, ST_DRW_RD: begin
        ram_en = 1'b1;
      end
      ST_CLR_WR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~clr_mask;
      end
      ST_DRW_WR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (second_r ? op_r.data1 : op_r.data0);
      end
      ST_RD_WAIT: begin
        ram_en = 1'b0;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          init_addr_r <= init_addr_r + ADDR_W'(1);
          if (init_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            op_r      <= q_head;
            cur_col_r <= {1'b0, q_head.col_lo};
            cur_pg_r  <= head_pg;
            second_r  <= !q_head.en0;
            unique case (q_head.kind)
              OP_CLEAR: state_r <= ST_CLR_WR;
              OP_DRAW:  state_r <= ST_DRW_WR;
              OP_READ:  state_r <= ST_RD_WAIT;
              OP_ZERO: begin
                out_valid_r <= 1'b1;
                out_data_r  <= 8'h00;
              end
            endcase
          end
        end
        ST_CLR_RD: begin
          state_r <= ST_CLR_WR;
        end
        ST_CLR_WR: begin
          if (cur_col_r + 9'd1 == op_r.col_hi) begin
            if (cur_pg_r == op_r.pg_hi) begin
              state_r <= ST_IDLE;
            end else begin
              cur_pg_r  <= cur_pg_r + 4'd1;
              cur_col_r <= {1'b0, op_r.col_lo};
              state_r   <= ST_CLR_RD;
            end
          end else begin
            cur_col_r <= cur_col_r + 9'd1;
            state_r   <= ST_CLR_RD;
          end
        end
        ST_DRW_RD: begin
          state_r <= ST_DRW_WR;
        end
        ST_DRW_WR: begin
          if (!second_r && op_r.en1) begin
            second_r <= 1'b1;
            cur_pg_r <= cur_pg_r + 4'd1;
            state_r  <= ST_DRW_RD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_RD_WAIT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= ram_rdata;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

### rtl/core/page_framebuffer_image_blit_core.sv
// ----------------------------------------------------------------------------
// page_framebuffer_image_blit_core: monochrome page framebuffer bitmap blit
// Blits vertically packed bitmaps into a page-organized frame memory and
// reads frame bytes back.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration words (dest_column, dest_row, image_width, image_height)
//   go in on cfg_* while the block is idle; cfg_ready is always high.
//   Command words go in on in_*: start (clear the clipped rectangle and arm
//   a blit), image byte (OR one byte into one or two pages), read (one frame
//   byte back). Only a read returns a word, on out_*.
//   Memory: the single-port frame memory sets the pace. Every touched frame
//   byte costs a read and a write: an image byte costs one pair for each of
//   its one or two pages, a start one pair per cleared byte, and a read word
//   passes from the frame memory's read register into the output register.
//   Commands that touch no memory, but for an off-screen read, are not queued.
//   A four-entry command queue lets the front accept words while the back
//   end works and while a read result waits for the receiver.
//   Reset: the back end writes zero to all 2**(page bits + column bits)
//   frame bytes, 1024 of them at the default 128x64 screen; in_stall stays
//   high until that pass ends.
//   Stall: a stalled result word holds on out_*; the queue fills and then
//   in_stall rises.
// ----------------------------------------------------------------------------
module page_framebuffer_image_blit_core import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = DEF_SCREEN_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  // command words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_pixel_byte,
  input  logic [2:0] in_read_page,
  input  logic [6:0] in_read_column,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  // configuration words
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic init_done;
  logic q_push, q_pop, q_full, q_empty;
  op_t  q_op, q_head;

  // Front end: clip commands against the screen and advance the stream.
  pfb_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pixel_byte  (in_pixel_byte),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .init_done      (init_done),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (q_op)
  );

  // Hold pending memory operations in command order.
  pfb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // Back end: frame memory and its read-modify-write sequencer.
  pfb_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .init_done     (init_done),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule

### rtl/core/pfb_checker.sv
// ----------------------------------------------------------------------------
// pfb_checker: port-level checks of the page framebuffer blit core
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module pfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_read_data))
    else $error("stalled result word changed");

  // Refuse commands as the frame memory clearing pass begins after reset.
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("command accepted right after reset");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind page_framebuffer_image_blit_core pfb_checker u_pfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the page framebuffer blit core
// Streams start, image-byte and read words through the core with random idle
// and stall bursts, keeps a shadow copy of the frame memory and the blit
// counters, and checks every returned frame byte against that copy.
// ----------------------------------------------------------------------------
module tb;
  import pfb_pkg::*;

  localparam int COLS            = DEF_SCREEN_COLUMNS;
  localparam int PAGES           = DEF_SCREEN_PAGES;
  localparam int ROWS            = PAGES * 8;
  localparam int TARGET_WORDS    = 1500;
  localparam int SETTLE_CYCLES   = 24;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WIND_DOWN_WORDS = 150;
  localparam longint TIMEOUT     = 64'd12_000_000;

  // Kinds of entries in the stimulus queue: a command word, a register word,
  // or a hold point where the sender waits for the core to go quiet.
  typedef enum logic [1:0] {
    W_COMMAND  = 2'd0,
    W_REGISTER = 2'd1,
    W_SETTLE   = 2'd2
  } word_kind_t;

  typedef struct packed {
    word_kind_t  kind;
    cmd_t        cmd;
    logic [7:0]  pixel;
    logic [2:0]  page;
    logic [6:0]  column;
    reg_idx_t    reg_index;
    logic [7:0]  reg_value;
  } tb_word_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_command     = CMD_NONE;
  logic [7:0] in_pixel_byte  = 8'h00;
  logic [2:0] in_read_page   = 3'd0;
  logic [6:0] in_read_column = 7'd0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_read_data;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index      = REG_DEST_COLUMN;
  logic [7:0] cfg_data       = 8'h00;

  page_framebuffer_image_blit_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pixel_byte  (in_pixel_byte),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Stimulus queue and the frame bytes that reads are due to return.
  tb_word_t   pending_words [$];
  logic [7:0] read_bytes_due [$];
  int         failures  = 0;
  logic       wind_down = 1'b0;

  // Shadow frame memory, blit counters and register copies.
  logic [7:0] frame_bytes [PAGES][COLS];
  logic       blit_armed;
  logic [3:0] page_count;
  logic [7:0] col_count;
  logic [7:0] reg_dest_column;
  logic [7:0] reg_dest_row;
  logic [7:0] reg_image_width;
  logic [6:0] reg_image_height;

  // Sender and receiver pacing.
  int send_gap    = 0;
  bit gaps_on     = 1'b1;
  int settle_left = -1;
  int stall_left  = 0;
  bit stalls_on   = 1'b1;

  // Register values as the stimulus plan sees them; used to aim reads and
  // to size the image stream of each scene.
  int plan_col    = 0;
  int plan_row    = 0;
  int plan_width  = 0;
  int plan_height = 8;
  int words_planned = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold reset low from time zero, then release it once.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the blit engine
  // ---------------------------------------------------------------------------
  function automatic int row_origin();
    return int'($signed(reg_dest_row));
  endfunction

  function automatic int image_pages();
    return (int'(reg_image_height) + 7) / 8;
  endfunction

  // With a negative origin only the pages that hold visible image rows are
  // drawn; bits below them are dropped.
  function automatic int visible_limit();
    int y, vis, lim;
    y = row_origin();
    if (y >= 0) return ROWS;
    vis = int'(reg_image_height) + y;
    if (vis < 1) return 0;
    lim = ((vis + 7) / 8) * 8;
    return (lim < ROWS) ? lim : ROWS;
  endfunction

  task automatic disarm_blit();
    blit_armed = 1'b0;
    page_count = '0;
    col_count  = '0;
  endtask

  task automatic set_blit_reg(reg_idx_t idx, logic [7:0] value);
    case (idx)
      REG_DEST_COLUMN:  reg_dest_column  = value;
      REG_DEST_ROW:     reg_dest_row     = value;
      REG_IMAGE_WIDTH:  reg_image_width  = value;
      REG_IMAGE_HEIGHT: reg_image_height = value[6:0];
      default: ;
    endcase
  endtask

  // Apply one accepted command word to the shadow frame; a read queues the
  // frame byte that the core must return.
  task automatic update_frame(cmd_t cmd, logic [7:0] pix, logic [2:0] pg, logic [6:0] col);
    int y, top, h, base, lim, r, x, b, col0, wid, hgt;
    y    = row_origin();
    col0 = int'(reg_dest_column);
    wid  = int'(reg_image_width);
    hgt  = int'(reg_image_height);
    case (cmd)
      CMD_START: begin
        disarm_blit();
        if (col0 < COLS && y < ROWS) begin
          top = (y < 0) ? 0 : y;
          h   = (y < 0) ? hgt + y : hgt;
          if (h >= 1) begin
            for (r = top; r < top + h && r < ROWS; r++)
              for (x = col0; x < col0 + wid && x < COLS; x++)
                frame_bytes[r / 8][x][r % 8] = 1'b0;
            blit_armed = (wid > 0) && (image_pages() > 0);
          end
        end
      end
      CMD_PIXEL: if (blit_armed) begin
        if (int'(col_count) >= wid || int'(page_count) >= image_pages()) begin
          // registers moved under a running blit: drop the byte and stop
          disarm_blit();
        end else begin
          base = y + 8 * int'(page_count);
          lim  = visible_limit();
          x    = col0 + int'(col_count);
          for (b = 0; b < 8; b++) begin
            r = base + b;
            if (pix[b] && r >= 0 && r < lim && x < COLS)
              frame_bytes[r / 8][x][r % 8] = 1'b1;
          end
          if (int'(col_count) + 1 >= wid) begin
            if (int'(page_count) + 1 >= image_pages()) begin
              disarm_blit();
            end else begin
              col_count  = '0;
              page_count = page_count + 4'd1;
            end
          end else begin
            col_count = col_count + 8'd1;
          end
        end
      end
      CMD_READ: read_bytes_due.push_back(frame_bytes[pg][col]);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_cmd(cmd_t cmd, logic [7:0] pix);
    tb_word_t w;
    w.kind      = W_COMMAND;
    w.cmd       = cmd;
    w.pixel     = pix;
    w.page      = 3'($urandom_range(0, 7));
    w.column    = 7'($urandom_range(0, 127));
    w.reg_index = REG_DEST_COLUMN;
    w.reg_value = '0;
    pending_words.push_back(w);
    words_planned++;
  endtask

  task automatic add_read(int pg, int col);
    add_cmd(CMD_READ, random_byte());
    pending_words[pending_words.size() - 1].page   = pg[2:0];
    pending_words[pending_words.size() - 1].column = col[6:0];
  endtask

  // Aim most reads at the pages and columns the current image covers.
  task automatic add_probe();
    int pg, col;
    if ($urandom_range(0, 3) == 0) begin
      pg  = $urandom_range(0, 7);
      col = $urandom_range(0, 127);
    end else begin
      col = (plan_col + $urandom_range(0, plan_width)) % COLS;
      pg  = ((plan_row < 0 ? 0 : plan_row / 8) + $urandom_range(0, (plan_height + 7) / 8)) % PAGES;
    end
    add_read(pg, col);
  endtask

  // A trailing read makes the core's queue drain in order; once its byte is
  // back and the settle time is over, registers may change.
  task automatic add_settle();
    tb_word_t w;
    add_probe();
    w = '0;
    w.kind = W_SETTLE;
    pending_words.push_back(w);
  endtask

  task automatic add_reg(reg_idx_t idx, int value);
    tb_word_t w;
    w = '0;
    w.kind      = W_REGISTER;
    w.reg_index = idx;
    w.reg_value = value[7:0];
    pending_words.push_back(w);
    case (idx)
      REG_DEST_COLUMN:  plan_col    = value & 255;
      REG_DEST_ROW:     plan_row    = value;
      REG_IMAGE_WIDTH:  plan_width  = value & 255;
      REG_IMAGE_HEIGHT: plan_height = value & 127;
      default: ;
    endcase
  endtask

  task automatic add_regs(int col, int row, int width, int height);
    add_settle();
    add_reg(REG_DEST_COLUMN, col);
    add_reg(REG_DEST_ROW, row);
    add_reg(REG_IMAGE_WIDTH, width);
    add_reg(REG_IMAGE_HEIGHT, height);
  endtask

  initial begin
    logic [7:0] clip_pattern [6];
    int new_col, new_row, new_width, new_height;
    int image_bytes, stream_len, pick, k;

    // Directed part. Read the cleared screen at both corners, then send an
    // unused command, a stray image byte and an empty-image start.
    add_read(0, 0);
    add_read(7, 127);
    add_cmd(CMD_NONE, 8'hA5);
    add_cmd(CMD_PIXEL, 8'hFF);
    add_cmd(CMD_START, 8'h00);
    add_cmd(CMD_PIXEL, 8'h3C);

    // Clip at the right edge and at the bottom row; one byte past the end.
    clip_pattern = '{8'hFF, 8'h81, 8'h7E, 8'h01, 8'h80, 8'hE0};
    add_regs(126, 61, 3, 9);
    add_cmd(CMD_START, 8'h00);
    for (k = 0; k < 6; k++) add_cmd(CMD_PIXEL, clip_pattern[k]);
    add_cmd(CMD_PIXEL, 8'hFF);
    add_read(7, 126);
    add_read(7, 127);

    // Hide top rows, then shrink the height under the running blit.
    add_regs(0, -5, 2, 12);
    add_cmd(CMD_START, 8'h00);
    add_cmd(CMD_PIXEL, 8'hFF);
    add_cmd(CMD_PIXEL, 8'hFF);
    add_settle();
    add_reg(REG_IMAGE_HEIGHT, 8);
    add_cmd(CMD_PIXEL, 8'hFF);
    add_read(1, 1);

    // Fully hidden image at the most negative row: no clear, no blit.
    add_regs(0, -128, 128, 64);
    add_cmd(CMD_START, 8'h00);

    // Random scenes: mostly a start and a complete image with random content,
    // some truncated or overrun streams, noise words and register changes.
    while (words_planned < TARGET_WORDS) begin
      new_col = ($urandom_range(0, 7) == 0) ? $urandom_range(96, 255) : $urandom_range(0, 127);
      case ($urandom_range(0, 7))
        0, 1:    new_row = -int'($urandom_range(1, 20));
        2:       new_row = int'($urandom_range(0, 255)) - 128;
        default: new_row = $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 15))
        0:       new_width = 0;
        1:       new_width = $urandom_range(64, 128);
        default: new_width = $urandom_range(1, 12);
      endcase
      new_height = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);

      pick = $urandom_range(0, 7);
      if (pick >= 3) begin
        add_regs(new_col, new_row, new_width, new_height);
      end else if (pick > 0) begin
        add_settle();
        case ($urandom_range(0, 3))
          0:       add_reg(REG_DEST_COLUMN, new_col);
          1:       add_reg(REG_DEST_ROW, new_row);
          2:       add_reg(REG_IMAGE_WIDTH, new_width);
          default: add_reg(REG_IMAGE_HEIGHT, new_height);
        endcase
      end
      add_cmd(CMD_START, random_byte());

      image_bytes = plan_width * ((plan_height + 7) / 8);
      if (image_bytes > 48) stream_len = $urandom_range(4, 48);
      else if ($urandom_range(0, 7) == 0) stream_len = $urandom_range(0, image_bytes);
      else stream_len = image_bytes;
      if ($urandom_range(0, 7) == 0) stream_len += $urandom_range(1, 3);

      for (k = 0; k < stream_len; k++) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
          // change one register while the blit is armed
          add_settle();
          case ($urandom_range(0, 3))
            0:       add_reg(REG_DEST_COLUMN, $urandom_range(0, 127));
            1:       add_reg(REG_DEST_ROW, int'($urandom_range(0, 71)) - 8);
            2:       add_reg(REG_IMAGE_WIDTH, $urandom_range(0, 12));
            default: add_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 24));
          endcase
        end else if (pick == 1) begin
          add_cmd(CMD_NONE, random_byte());
        end else if (pick == 2) begin
          add_cmd(CMD_START, random_byte());
        end else if (pick <= 8) begin
          add_probe();
        end
        add_cmd(CMD_PIXEL, random_byte());
      end
      repeat ($urandom_range(1, 4)) add_probe();
    end
    add_settle();
  end

  // ---------------------------------------------------------------------------
  // Driver: feed command and register words from the queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tb_word_t w;
    logic     in_busy;
    logic     cfg_busy;
    in_busy  = in_valid;
    cfg_busy = cfg_valid;
    if (!rst_n) begin
      in_busy  = 1'b0;
      cfg_busy = 1'b0;
    end else begin
      // Retire words taken at this edge.
      if (in_valid && !in_stall) in_busy = 1'b0;
      if (cfg_valid && cfg_ready) cfg_busy = 1'b0;
      // Alternate stretches with and without idle bursts.
      if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
      if (!in_busy && !cfg_busy && pending_words.size() > 0) begin
        w = pending_words[0];
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          case (w.kind)
            W_COMMAND: begin
              if (gaps_on && !wind_down && $urandom_range(0, 5) == 0) begin
                // idle now and set a random send gap
                send_gap = $urandom_range(0, 3);
              end else begin
                void'(pending_words.pop_front());
                in_command     <= w.cmd;
                in_pixel_byte  <= w.pixel;
                in_read_page   <= w.page;
                in_read_column <= w.column;
                in_busy = 1'b1;
              end
            end
            W_REGISTER: begin
              void'(pending_words.pop_front());
              cfg_index <= w.reg_index;
              cfg_data  <= w.reg_value;
              cfg_busy = 1'b1;
            end
            default: begin
              // Hold until every due byte is back, then let the core settle.
              if (read_bytes_due.size() != 0) begin
                settle_left = -1;
              end else if (settle_left < 0) begin
                settle_left = SETTLE_CYCLES;
              end else if (settle_left == 0) begin
                void'(pending_words.pop_front());
                settle_left = -1;
              end else begin
                settle_left--;
              end
            end
          endcase
        end
      end
      wind_down <= (pending_words.size() < WIND_DOWN_WORDS);
    end
    in_valid  <= in_busy;
    cfg_valid <= cfg_busy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result words, then track accepted words in the shadow model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] due;
    logic       stall_next;
    int         p, c;
    if (!rst_n) begin
      for (p = 0; p < PAGES; p++)
        for (c = 0; c < COLS; c++)
          frame_bytes[p][c] = 8'h00;
      disarm_blit();
      reg_dest_column  = 8'd0;
      reg_dest_row     = 8'd0;
      reg_image_width  = 8'd0;
      reg_image_height = 7'd8;
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      // Compare first: a word leaving now belongs to an earlier read.
      if (out_valid && !out_stall) begin
        if (read_bytes_due.size() == 0) begin
          failures++;
          $error("read_data: expected no word, actual %02h", out_read_data);
        end else begin
          due = read_bytes_due.pop_front();
          if (out_read_data !== due) begin
            failures++;
            $error("read_data: expected %02h, actual %02h", due, out_read_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) set_blit_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall)
        update_frame(cmd_t'(in_command), in_pixel_byte, in_read_page, in_read_column);

      // Stall the result channel in random bursts.
      if ($urandom_range(0, 63) == 0) stalls_on = !stalls_on;
      if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (stalls_on && !wind_down && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Wait for the queue and the due bytes to drain, give the core time to
  // show any stray word, then report.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || cfg_valid || read_bytes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && read_bytes_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #TIMEOUT;
    $display("status: fail");
    $finish;
  end

endmodule
